/* rtl/wbps_pkg.sv */
// ----------------------------------------------------------------------------
// wbps_pkg
// Types and constants shared by the wildcard byte pattern scanner.
// ----------------------------------------------------------------------------
package wbps_pkg;

   localparam int BYTE_BITS       = 8;
   localparam int PAT_WORDS       = 4;
   localparam int PAT_WORD_BITS   = 64;
   localparam int PAT_BYTES_TOTAL = PAT_WORDS * PAT_WORD_BITS / BYTE_BITS;
   localparam int PAT_INDEX_BITS  = $clog2(PAT_BYTES_TOTAL);
   localparam int LENGTH_BITS     = 6;
   localparam int MATCH_OFS_BITS  = 32;
   localparam int EXT_OFS_BITS    = 64;
   localparam int CSR_INDEX_BITS  = 3;

   localparam logic [BYTE_BITS-1:0] WILDCARD = 8'h00;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_WORD_0 = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_WORD_1 = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_WORD_2 = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_WORD_3 = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_LENGTH = 3'd4;

   localparam logic [LENGTH_BITS-1:0] LENGTH_RESET = 6'd1;

   typedef struct packed {
      logic [BYTE_BITS-1:0] data_byte;
      logic                 first_byte;
      logic                 last_byte;
   } req_type;

   typedef struct packed {
      logic [MATCH_OFS_BITS-1:0] match_offset;
      logic                      matched;
      logic                      region_done;
   } rsp_type;

endpackage

/* rtl/wbps_pattern.sv */
// ----------------------------------------------------------------------------
// wbps_pattern
// Pattern registers and the aligned compare pattern derived from them.
// ----------------------------------------------------------------------------
module wbps_pattern #(
   parameter int PATTERN_MAX = 32,
   parameter int LEN_BITS    = 6
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [wbps_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [wbps_pkg::PAT_WORD_BITS-1:0]     csr_data,
   output logic [LEN_BITS-1:0]                    pat_len,
   output logic [wbps_pkg::BYTE_BITS-1:0]         pat_bytes [PATTERN_MAX],
   output logic                                   pat_care  [PATTERN_MAX]
);

   logic [wbps_pkg::PAT_WORD_BITS-1:0] word_ff [wbps_pkg::PAT_WORDS];
   logic [wbps_pkg::LENGTH_BITS-1:0]   length_ff;

   logic [wbps_pkg::PAT_WORDS*wbps_pkg::PAT_WORD_BITS-1:0] pat_all;
   logic [wbps_pkg::LENGTH_BITS-1:0]   len_eff;
   logic [wbps_pkg::LENGTH_BITS-1:0]   k_full [PATTERN_MAX];
   logic [wbps_pkg::BYTE_BITS-1:0]     bytes_in [PATTERN_MAX];
   logic                               care_in  [PATTERN_MAX];
   logic [wbps_pkg::BYTE_BITS-1:0]     bytes_ff [PATTERN_MAX];
   logic                               care_ff  [PATTERN_MAX];
   logic [LEN_BITS-1:0]                len_ff;
   logic                               csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < wbps_pkg::PAT_WORDS; w++) begin
            word_ff[w] <= '0;
         end
         length_ff <= wbps_pkg::LENGTH_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            wbps_pkg::CSR_PATTERN_WORD_0: word_ff[0] <= csr_data;
            wbps_pkg::CSR_PATTERN_WORD_1: word_ff[1] <= csr_data;
            wbps_pkg::CSR_PATTERN_WORD_2: word_ff[2] <= csr_data;
            wbps_pkg::CSR_PATTERN_WORD_3: word_ff[3] <= csr_data;
            wbps_pkg::CSR_PATTERN_LENGTH:
               length_ff <= csr_data[wbps_pkg::LENGTH_BITS-1:0];
            default: ;
         endcase
      end
   end

   // pattern byte k lines up with window entry len-1-k (entry 0 is newest)
   always_comb begin
      pat_all = {word_ff[3], word_ff[2], word_ff[1], word_ff[0]};
      len_eff = length_ff;
      if (length_ff == '0) begin
         len_eff = wbps_pkg::LENGTH_BITS'(1);
      end else if (length_ff > wbps_pkg::LENGTH_BITS'(PATTERN_MAX)) begin
         len_eff = wbps_pkg::LENGTH_BITS'(PATTERN_MAX);
      end
      for (int i = 0; i < PATTERN_MAX; i++) begin
         k_full[i]   = len_eff - wbps_pkg::LENGTH_BITS'(1) - wbps_pkg::LENGTH_BITS'(i);
         bytes_in[i] = pat_all[k_full[i][wbps_pkg::PAT_INDEX_BITS-1:0]*wbps_pkg::BYTE_BITS
                               +: wbps_pkg::BYTE_BITS];
         care_in[i]  = (wbps_pkg::LENGTH_BITS'(i) < len_eff) &&
                       (bytes_in[i] != wbps_pkg::WILDCARD);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= LEN_BITS'(1);
         for (int i = 0; i < PATTERN_MAX; i++) begin
            bytes_ff[i] <= '0;
            care_ff[i]  <= 1'b0;
         end
      end else begin
         len_ff <= len_eff[LEN_BITS-1:0];
         for (int i = 0; i < PATTERN_MAX; i++) begin
            bytes_ff[i] <= bytes_in[i];
            care_ff[i]  <= care_in[i];
         end
      end
   end

   assign pat_len   = len_ff;
   assign pat_bytes = bytes_ff;
   assign pat_care  = care_ff;

endmodule

/* rtl/wbps_match.sv */
// ----------------------------------------------------------------------------
// wbps_match
// Parallel compare of the sliding window against the aligned pattern.
// ----------------------------------------------------------------------------
module wbps_match #(
   parameter int PATTERN_MAX = 32,
   parameter int LEN_BITS    = 6
) (
   input  logic [wbps_pkg::BYTE_BITS-1:0] window    [PATTERN_MAX],
   input  logic [wbps_pkg::BYTE_BITS-1:0] pat_bytes [PATTERN_MAX],
   input  logic                           pat_care  [PATTERN_MAX],
   input  logic [LEN_BITS-1:0]            fill,
   input  logic [LEN_BITS-1:0]            pat_len,
   output logic                           hit
);

   logic all_equal;

   always_comb begin
      all_equal = 1'b1;
      for (int i = 0; i < PATTERN_MAX; i++) begin
         if (pat_care[i] && (window[i] != pat_bytes[i])) begin
            all_equal = 1'b0;
         end
      end
      // no match until the window holds a full pattern length
      hit = all_equal && (fill >= pat_len);
   end

endmodule

/* rtl/wildcard_byte_pattern_scanner.sv */
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner
// Streams a region one byte per word and reports every window that matches
// a wildcard byte pattern, plus a done word on the last byte of the region.
// ----------------------------------------------------------------------------
// Takes one byte every cycle and sustains that rate as long as the result
// side keeps up. A byte is shifted into the window when accepted; after
// that the parallel window compare and the start offset subtract load the
// result register once it is free. Bytes that neither match nor end the
// region produce no result. While a result is stalled, one more byte can
// be taken before req_ready drops. Pattern registers take effect on the
// first byte accepted after the write.
module wildcard_byte_pattern_scanner #(
   parameter int PATTERN_MAX = 32,
   parameter int OFFSET_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  wbps_pkg::req_type                   req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output wbps_pkg::rsp_type                   rsp_payload,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [wbps_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [wbps_pkg::PAT_WORD_BITS-1:0]  csr_data
);

   localparam int LEN_BITS = $clog2(PATTERN_MAX + 1);

   logic [LEN_BITS-1:0]            pat_len;
   logic [wbps_pkg::BYTE_BITS-1:0] pat_bytes [PATTERN_MAX];
   logic                           pat_care  [PATTERN_MAX];

   logic [wbps_pkg::BYTE_BITS-1:0] window_ff [PATTERN_MAX];
   logic [LEN_BITS-1:0]            fill_ff;
   logic [LEN_BITS-1:0]            fill_in;
   logic [OFFSET_BITS-1:0]         offset_ff;
   logic [OFFSET_BITS-1:0]         offset_in;
   logic [OFFSET_BITS-1:0]         cur_offset;

   logic                           a_valid_ff;
   logic                           a_last_ff;
   logic [OFFSET_BITS-1:0]         a_cur_ff;

   logic                           rsp_valid_ff;
   wbps_pkg::rsp_type              rsp_payload_ff;
   wbps_pkg::rsp_type              rsp_payload_in;

   logic                           req_accept;
   logic                           out_free;
   logic                           hit;
   logic [OFFSET_BITS-1:0]         start_offset;
   logic [wbps_pkg::EXT_OFS_BITS-1:0] start_ext;

   wbps_pattern #(
      .PATTERN_MAX (PATTERN_MAX),
      .LEN_BITS    (LEN_BITS)
   ) u_pattern (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .pat_len   (pat_len),
      .pat_bytes (pat_bytes),
      .pat_care  (pat_care)
   );

   wbps_match #(
      .PATTERN_MAX (PATTERN_MAX),
      .LEN_BITS    (LEN_BITS)
   ) u_match (
      .window    (window_ff),
      .pat_bytes (pat_bytes),
      .pat_care  (pat_care),
      .fill      (fill_ff),
      .pat_len   (pat_len),
      .hit       (hit)
   );

   assign out_free   = !rsp_valid_ff || rsp_ready;
   // window may only shift once the byte in it has been judged
   assign req_ready  = !a_valid_ff || out_free;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      cur_offset = req_payload.first_byte ? '0 : offset_ff;
      offset_in  = (cur_offset != '1) ? cur_offset + OFFSET_BITS'(1) : cur_offset;
      if (req_payload.first_byte) begin
         fill_in = LEN_BITS'(1);
      end else if (fill_ff < LEN_BITS'(PATTERN_MAX)) begin
         fill_in = fill_ff + LEN_BITS'(1);
      end else begin
         fill_in = fill_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         offset_ff  <= '0;
         a_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            fill_ff    <= fill_in;
            offset_ff  <= offset_in;
            a_valid_ff <= 1'b1;
         end else if (out_free) begin
            a_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         window_ff[0] <= req_payload.data_byte;
         for (int i = 1; i < PATTERN_MAX; i++) begin
            window_ff[i] <= window_ff[i-1];
         end
         a_last_ff <= req_payload.last_byte;
         a_cur_ff  <= cur_offset;
      end
   end

   // offset of the window start, never below zero on a hit
   assign start_offset = a_cur_ff - OFFSET_BITS'(pat_len - LEN_BITS'(1));
   assign start_ext    = wbps_pkg::EXT_OFS_BITS'(start_offset);

   always_comb begin
      rsp_payload_in.match_offset = hit ? start_ext[wbps_pkg::MATCH_OFS_BITS-1:0] : '0;
      rsp_payload_in.matched      = hit;
      rsp_payload_in.region_done  = a_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= a_valid_ff && (hit || a_last_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && a_valid_ff) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

/* rtl/wbps_checker.sv */
// ----------------------------------------------------------------------------
// wbps_checker
// Port level checks for the wildcard byte pattern scanner.
// ----------------------------------------------------------------------------
module wbps_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input wbps_pkg::rsp_type rsp_payload
);

   // a stalled result word holds its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result word changed while stalled");

   // every result is either a match or the end of the region
   a_rsp_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.matched || rsp_payload.region_done)
      else $error("result word with neither match nor done");

   // a done word without a match carries a zero offset
   a_rsp_zero_ofs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.matched |-> rsp_payload.match_offset == '0)
      else $error("nonzero offset on a word without match");

   // input backpressure only comes from a stalled result
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled while result side is free");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind wildcard_byte_pattern_scanner wbps_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
